### hw/rtl/swls_pkg.sv
// ----------------------------------------------------------------------------
// swls_pkg: shared types and codes of the stack with linear search
// Request and response beats, operation and status codes, cell control and
// controller states.
// ----------------------------------------------------------------------------
package swls_pkg;

  // operation codes carried in the request beat
  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  // status codes carried in the response beat
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // request beat
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } req_t;

  // response beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic               found;
    logic [3:0]         found_index;
    logic signed [31:0] top_value;
    logic [4:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;   // shift words one cell toward the bottom
    logic pop;    // shift words one cell toward the top
    logic walk;   // advance the search token one cell
    logic flush;  // drop any search token
  } cell_ctrl_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

endpackage

### hw/rtl/stack_with_linear_search.sv
// ----------------------------------------------------------------------------
// stack_with_linear_search: LIFO stack of signed words with top-down search
// A chain of cells, cell 0 on top; push and pop shift the whole chain, and a
// search token walks down from the top one cell per cycle.
// ----------------------------------------------------------------------------
//  channel   | ports                        | handshake
//  ----------+------------------------------+-------------------------------
//  request   | start, busy, req_i           | taken when start & !busy
//  response  | rsp_valid_o, rsp_o           | one-cycle strobe, no back-pressure
//
//  push, pop and the unused code: response in the cycle after the request beat;
//  busy stays low, so a new request may follow every cycle.
//  search: busy while the token walks k cells, k from 1 up to the count, response
//  in the cycle after; the token moves one cell per cycle and stops at the first
//  hit. A search on an empty stack answers like the unused code.
//  reset clears the count, the tokens and the controller; stored words are
//  not cleared. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module stack_with_linear_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  swls_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output swls_pkg::rsp_t rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  swls_pkg::state_e      state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         step_q, step_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  swls_pkg::rsp_t        rsp_q, rsp_d;
  logic                  rsp_valid_q, rsp_valid_d;

  swls_pkg::cell_ctrl_t  ctrl;
  logic                  seed;
  logic                  accept;
  logic                  full;
  logic                  hit_any;
  logic [DATA_WIDTH-1:0] in_word;
  logic [CW-1:0]         match_idx;

  logic [DATA_WIDTH-1:0] words [DEPTH+1];
  logic                  tokens [DEPTH+1];
  logic [DEPTH-1:0]      hits;

  // word as stored, and word as reported
  assign in_word = DATA_WIDTH'(req_i.value);

  function automatic logic signed [31:0] out_word(input logic [DATA_WIDTH-1:0] w);
    logic signed [DATA_WIDTH-1:0] s;
    s = w;
    return 32'(s);
  endfunction

  // cell chain
  assign tokens[0]    = seed;
  assign words[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_word;
    if (i == 0) begin : g_top
      assign up_word = in_word;
    end else begin : g_inner
      assign up_word = words[i-1];
    end
    swls_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (key_q),
      .up_word_i   (up_word),
      .down_word_i (words[i+1]),
      .token_i     (tokens[i]),
      .word_o      (words[i]),
      .token_o     (tokens[i+1]),
      .hit_o       (hits[i])
    );
  end

  assign hit_any   = |hits;
  assign accept    = start & (state_q == swls_pkg::ST_IDLE);
  assign busy      = (state_q != swls_pkg::ST_IDLE);
  assign full      = (count_q == CW'(DEPTH));
  assign match_idx = count_q - CW'(1) - CW'(step_q);

  // controller: next state, cell commands and response beat
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    key_d       = key_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    ctrl        = '0;
    seed        = 1'b0;

    unique case (state_q)
      swls_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_d              = '0;
          rsp_d.status       = swls_pkg::STAT_OK;
          rsp_d.top_value    = (count_q != '0) ? out_word(words[0]) : '0;
          rsp_valid_d        = 1'b1;
          unique case (req_i.action)
            swls_pkg::ACT_PUSH: begin
              if (full) begin
                rsp_d.status = swls_pkg::STAT_FULL;
              end else begin
                ctrl.push       = 1'b1;
                count_d         = count_q + CW'(1);
                rsp_d.top_value = out_word(in_word);
              end
            end
            swls_pkg::ACT_POP: begin
              if (count_q == '0) begin
                rsp_d.status = swls_pkg::STAT_EMPTY;
              end else begin
                ctrl.pop           = 1'b1;
                count_d            = count_q - CW'(1);
                rsp_d.popped_value = out_word(words[0]);
                rsp_d.top_value    = (count_q > CW'(1)) ? out_word(words[1]) : '0;
              end
            end
            swls_pkg::ACT_SEARCH: begin
              if (count_q != '0) begin
                // launch the token at the top cell
                rsp_valid_d = 1'b0;
                seed        = 1'b1;
                ctrl.walk   = 1'b1;
                key_d       = in_word;
                step_d      = '0;
                state_d     = swls_pkg::ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
          rsp_d.entry_count = 5'(count_d);
          rsp_d.is_empty    = (count_d == '0);
        end
      end

      swls_pkg::ST_SEARCH: begin
        priority if (hit_any) begin
          rsp_d             = '0;
          rsp_d.found       = 1'b1;
          rsp_d.found_index = 4'(match_idx);
          rsp_d.top_value   = out_word(words[0]);
          rsp_d.entry_count = 5'(count_q);
          rsp_valid_d       = 1'b1;
          ctrl.flush        = 1'b1;
          state_d           = swls_pkg::ST_IDLE;
        end else if (CW'(step_q) == count_q - CW'(1)) begin
          rsp_d             = '0;
          rsp_d.top_value   = out_word(words[0]);
          rsp_d.entry_count = 5'(count_q);
          rsp_valid_d       = 1'b1;
          ctrl.flush        = 1'b1;
          state_d           = swls_pkg::ST_IDLE;
        end else begin
          ctrl.walk = 1'b1;
          step_d    = step_q + IW'(1);
        end
      end

      default: begin
        state_d = swls_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swls_pkg::ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTH
  // at most one cell holds the token and matches
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hits))
    else $error("more than one search hit");

  // a response beat never coincides with a running search
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_q |-> !busy)
    else $error("response beat while busy");

  // a search leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == swls_pkg::ST_SEARCH |=> count_q == $past(count_q))
    else $error("count changed during search");

  // an accepted push below the limit grows the stack by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.action == swls_pkg::ACT_PUSH && !full
    |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the stack");

  // the count stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("count beyond depth");
`endif

endmodule

### hw/rtl/swls_cell.sv
// ----------------------------------------------------------------------------
// swls_cell: one stack slot of the cell chain
// Holds one word, shifts it to a neighbor on push or pop, and carries the
// search token that compares the stored word against the key.
// ----------------------------------------------------------------------------
module swls_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swls_pkg::cell_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0]  key_i,
  input  logic [DATA_WIDTH-1:0]  up_word_i,
  input  logic [DATA_WIDTH-1:0]  down_word_i,
  input  logic                   token_i,
  output logic [DATA_WIDTH-1:0]  word_o,
  output logic                   token_o,
  output logic                   hit_o
);

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  token_q, token_d;

  // word shift
  always_comb begin
    word_d = word_q;
    if (ctrl_i.push) begin
      word_d = up_word_i;
    end else if (ctrl_i.pop) begin
      word_d = down_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // search token
  always_comb begin
    token_d = token_q;
    if (ctrl_i.flush) begin
      token_d = 1'b0;
    end else if (ctrl_i.walk) begin
      token_d = token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
    end else begin
      token_q <= token_d;
    end
  end

  assign word_o  = word_q;
  assign token_o = token_q;
  assign hit_o   = token_q & (word_q == key_i);

endmodule

### test/stack_with_linear_search_tb.sv
// ----------------------------------------------------------------------------
// stack_with_linear_search_tb: self-checking bench for the stack with search
// Drives push, pop, search and the unused code through the command port.
// Every response is checked field by field against a behavioral stack model.
// Stimulus runs in several idle profiles and drains between phases.
// ----------------------------------------------------------------------------
module stack_with_linear_search_tb;

  localparam int          STACK_DEPTH = 16;
  localparam logic [1:0]  ACT_NONE    = 2'd3;   // unused code, no effect
  localparam int          RUN_LIMIT   = 2_000_000;
  localparam int          TAIL_CYCLES = 2 * STACK_DEPTH + 4;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cmd_start = 1'b0;
  logic cmd_busy;
  swls_pkg::req_t cmd_req = '0;
  logic rsp_valid;
  swls_pkg::rsp_t rsp_beat;

  stack_with_linear_search uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (cmd_start),
    .busy       (cmd_busy),
    .req_i      (cmd_req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp_beat)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("TEST FAILED");
    $finish;
  end

  // queues and bookkeeping
  swls_pkg::req_t pending_req[$];
  swls_pkg::rsp_t expected_rsp[$];
  logic signed [31:0] plan_stack[$];   // stack contents as seen by the generator
  logic cmd_taken = 1'b0;
  int   idle_pct = 0;
  int   errors = 0;
  int   n_push = 0, n_full = 0, n_pop = 0, n_underflow = 0;
  int   n_search = 0, n_hit = 0, n_none = 0;

  // behavioral stack
  logic signed [31:0] word_store[STACK_DEPTH];
  int words_held = 0;

  // apply one operation to the stack and return its response beat
  function automatic swls_pkg::rsp_t apply_op(swls_pkg::req_t r);
    swls_pkg::rsp_t o;
    int   i;
    o = '0;
    case (r.action)
      swls_pkg::ACT_PUSH: begin
        n_push++;
        if (words_held == STACK_DEPTH) begin
          o.status = swls_pkg::STAT_FULL;
          n_full++;
        end else begin
          word_store[words_held] = r.value;
          words_held++;
        end
      end
      swls_pkg::ACT_POP: begin
        n_pop++;
        if (words_held == 0) begin
          o.status = swls_pkg::STAT_EMPTY;
          n_underflow++;
        end else begin
          words_held--;
          o.popped_value = word_store[words_held];
        end
      end
      swls_pkg::ACT_SEARCH: begin
        n_search++;
        // topmost match wins
        for (i = words_held - 1; i >= 0 && !o.found; i--) begin
          if (word_store[i] == r.value) begin
            o.found       = 1'b1;
            o.found_index = i[3:0];
          end
        end
        if (o.found) n_hit++;
      end
      default: n_none++;
    endcase
    o.top_value   = (words_held > 0) ? word_store[words_held - 1] : '0;
    o.entry_count = words_held[4:0];
    o.is_empty    = (words_held == 0);
    return o;
  endfunction

  // print one mismatch line and count it
  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("mismatch %s: got %h want %h at %0t", name, got, want, $time);
      errors++;
    end
  endtask

  // monitor: check the response beat first, then record a taken request
  always @(posedge clk_i) begin
    swls_pkg::rsp_t want;
    if (rst_ni) begin
      if (rsp_valid) begin
        if (expected_rsp.size() == 0) begin
          check_field("unexpected beat", 32'd1, 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          check_field("status", 32'(rsp_beat.status), 32'(want.status));
          check_field("popped_value", rsp_beat.popped_value, want.popped_value);
          check_field("found", 32'(rsp_beat.found), 32'(want.found));
          check_field("found_index", 32'(rsp_beat.found_index), 32'(want.found_index));
          check_field("top_value", rsp_beat.top_value, want.top_value);
          check_field("entry_count", 32'(rsp_beat.entry_count), 32'(want.entry_count));
          check_field("is_empty", 32'(rsp_beat.is_empty), 32'(want.is_empty));
        end
      end
      if (cmd_start && !cmd_busy) expected_rsp.insert(expected_rsp.size(), apply_op(cmd_req));
      cmd_taken <= cmd_start && !cmd_busy;
    end
  end

  // driver: present the next request once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_start <= 1'b0;
    end else if (!cmd_start || cmd_taken) begin
      if (pending_req.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cmd_start <= 1'b1;
        cmd_req   <= pending_req.pop_front();
      end else begin
        cmd_start <= 1'b0;
      end
    end
  end

  // queue one request and track the stack as the generator sees it
  task automatic add_item(logic [1:0] action, logic signed [31:0] value);
    swls_pkg::req_t r;
    r.action = action;
    r.value  = value;
    pending_req.insert(pending_req.size(), r);
    if (action == swls_pkg::ACT_PUSH && plan_stack.size() < STACK_DEPTH)
      plan_stack.insert(plan_stack.size(), value);
    if (action == swls_pkg::ACT_POP && plan_stack.size() > 0)
      plan_stack.delete(plan_stack.size() - 1);
  endtask

  // mix of full-range words, small values and extremes so that keys repeat
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(3))
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(7)) - 3;
      default: begin
        case ($urandom_range(3))
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  // one random request; push_pct sets the fill or drain trend
  task automatic add_random(int push_pct);
    int roll;
    logic signed [31:0] key;
    roll = $urandom_range(99);
    if (roll < 3) begin
      add_item(ACT_NONE, pick_word());
    end else if (roll < 3 + push_pct) begin
      add_item(swls_pkg::ACT_PUSH, pick_word());
    end else if (roll < 28 + push_pct) begin
      key = pick_word();
      if (plan_stack.size() > 0 && $urandom_range(9) < 6)
        key = plan_stack[$urandom_range(plan_stack.size() - 1)];
      add_item(swls_pkg::ACT_SEARCH, key);
    end else begin
      add_item(swls_pkg::ACT_POP, pick_word());
    end
  endtask

  // wait until every queued beat is taken and every response has come
  task automatic drain();
    while (pending_req.size() > 0 || cmd_start || expected_rsp.size() > 0)
      @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int phase_idle[4];
    int trend;
    phase_idle = '{0, 46, 0, 24};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-stack cases, extremes, fill to full, deep search
    add_item(swls_pkg::ACT_POP, 32'sd5);
    add_item(swls_pkg::ACT_SEARCH, 32'sd0);
    add_item(ACT_NONE, -32'sd1);
    add_item(swls_pkg::ACT_PUSH, 32'sh7fff_ffff);
    add_item(swls_pkg::ACT_PUSH, 32'sh8000_0000);
    add_item(swls_pkg::ACT_PUSH, -32'sd1);
    add_item(swls_pkg::ACT_PUSH, 32'sd0);
    for (int k = 0; k < STACK_DEPTH - 4; k++) add_item(swls_pkg::ACT_PUSH, $urandom);
    add_item(swls_pkg::ACT_PUSH, 32'sh1234_5678);        // dropped, stack full
    add_item(swls_pkg::ACT_SEARCH, 32'sh7fff_ffff);      // walks to the bottom entry
    add_item(swls_pkg::ACT_SEARCH, 32'sh8000_0000);
    add_item(ACT_NONE, 32'sd7);
    add_item(swls_pkg::ACT_POP, 32'sd0);
    drain();

    // random phases, each with its own idle profile
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      trend = 45;
      for (int k = 0; k < 232; k++) begin
        if (k % 20 == 0) begin
          case ($urandom_range(2))
            0:       trend = 20;
            1:       trend = 45;
            default: trend = 65;
          endcase
        end
        add_random(trend);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d pushes (%0d on full), %0d pops (%0d on empty)",
             n_push, n_full, n_pop, n_underflow);
    $display("covered %0d searches (%0d hits), %0d unused codes, idle 0/46/24 pct",
             n_search, n_hit, n_none);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
